// ----- sv/wsfe_pkg.sv -----
`timescale 1ns / 1ps
// Package for the websocket binary frame encoder: header constants,
// length-encoding kinds, and the key byte, length classification and header byte functions.
// No dependencies.
package wsfe_pkg;

   localparam logic [7:0]  HDR_FIN_BINARY = 8'h82;
   localparam logic [7:0]  HDR_MASK_BIT   = 8'h80;
   localparam logic [6:0]  LEN_CODE16     = 7'd126;
   localparam logic [6:0]  LEN_CODE64     = 7'd127;
   localparam logic [31:0] LEN_MAX16      = 32'h0000_FFFF;
   localparam logic [31:0] LEN_MIN16      = 32'd126;

   // Byte index of the final header byte for each length encoding
   localparam logic [3:0]  LAST_IDX_SHORT = 4'd5;
   localparam logic [3:0]  LAST_IDX_16    = 4'd7;
   localparam logic [3:0]  LAST_IDX_64    = 4'd13;

   localparam logic [0:0]  ACT_START  = 1'b0;
   localparam logic [0:0]  ACT_DATA   = 1'b1;

   typedef enum logic [1:0] {
      LEN_SHORT = 2'd0,
      LEN_EXT16 = 2'd1,
      LEN_EXT64 = 2'd2
   } len_kind_type;

   // Pick one key byte; position 0 is bits 31..24
   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0:    b = key[31:24];
         2'd1:    b = key[23:16];
         2'd2:    b = key[15:8];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

   // Classify a payload length into its header encoding
   function automatic len_kind_type len_kind(input logic [31:0] len);
      len_kind_type k;
      priority if (len < LEN_MIN16) begin
         k = LEN_SHORT;
      end else if (len <= LEN_MAX16) begin
         k = LEN_EXT16;
      end else begin
         k = LEN_EXT64;
      end
      return k;
   endfunction

   function automatic logic [3:0] last_idx(input len_kind_type kind);
      logic [3:0] n;
      unique case (kind)
         LEN_SHORT: n = LAST_IDX_SHORT;
         LEN_EXT16: n = LAST_IDX_16;
         default:   n = LAST_IDX_64;
      endcase
      return n;
   endfunction

   // Header byte at a given index of the header run
   function automatic logic [7:0] hdr_byte(input len_kind_type kind, input logic [3:0] idx,
                                           input logic [31:0] len, input logic [31:0] key);
      logic [7:0] b;
      logic [3:0] rel;
      b   = 8'h00;
      rel = 4'd0;
      if (idx == 4'd0) begin
         b = HDR_FIN_BINARY;
      end else begin
         unique case (kind)
            LEN_SHORT: begin
               if (idx == 4'd1) begin
                  b = HDR_MASK_BIT | {1'b0, len[6:0]};
               end else begin
                  rel = idx - 4'd2;
                  b   = key_byte(key, rel[1:0]);
               end
            end
            LEN_EXT16: begin
               priority if (idx == 4'd1) begin
                  b = HDR_MASK_BIT | {1'b0, LEN_CODE16};
               end else if (idx == 4'd2) begin
                  b = len[15:8];
               end else if (idx == 4'd3) begin
                  b = len[7:0];
               end else begin
                  rel = idx - 4'd4;
                  b   = key_byte(key, rel[1:0]);
               end
            end
            default: begin
               priority if (idx == 4'd1) begin
                  b = HDR_MASK_BIT | {1'b0, LEN_CODE64};
               end else if (idx < 4'd6) begin
                  b = 8'h00;
               end else if (idx == 4'd6) begin
                  b = len[31:24];
               end else if (idx == 4'd7) begin
                  b = len[23:16];
               end else if (idx == 4'd8) begin
                  b = len[15:8];
               end else if (idx == 4'd9) begin
                  b = len[7:0];
               end else begin
                  rel = idx - 4'd10;
                  b   = key_byte(key, rel[1:0]);
               end
            end
         endcase
      end
      return b;
   endfunction

endpackage

// ----- sv/websocket_binary_frame_encoder_top.sv -----
`timescale 1ns / 1ps
// Websocket binary frame encoder: a payload beat gives one masked byte, a start beat gives
// a 6, 8 or 14 byte header run, one byte per cycle while the result side does not stall.
// First result passes through the work register, then the result register.
// Throughput: one payload beat per cycle unless the output stalls; a start beat holds the input for its run length.
// Reset (synchronous, active high) clears frame state and empties both registers.
// Depends on wsfe_pkg.
module websocket_binary_frame_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_payload_length,
   input  logic [31:0] req_mask_key,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_frame,
   output logic        rsp_sequence_error
);

   // Frame state
   logic [31:0] held_key_ff, held_key_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [1:0]  key_pos_ff, key_pos_in;
   logic        frame_open_ff, frame_open_in;

   // Work register: the beat whose results are being emitted
   logic                  wrk_valid_ff, wrk_valid_in;
   logic                  wrk_start_ff, wrk_start_in;
   wsfe_pkg::len_kind_type wrk_kind_ff, wrk_kind_in;
   logic [31:0]           wrk_len_ff, wrk_len_in;
   logic [31:0]           wrk_key_ff, wrk_key_in;
   logic [7:0]            wrk_byte_ff, wrk_byte_in;
   logic                  wrk_eof_ff, wrk_eof_in;
   logic                  wrk_err_ff, wrk_err_in;
   logic [3:0]            wrk_idx_ff, wrk_idx_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_eof_ff, rsp_eof_in;
   logic       rsp_err_ff, rsp_err_in;

   logic       out_load;
   logic       wrk_last;
   logic       emit;
   logic       accept;
   logic [7:0] cur_byte;
   logic       cur_eof;
   logic [31:0] left_dec;

   // Current result from the work register
   always_comb begin
      out_load = !rsp_valid_ff || !rsp_stall;
      wrk_last = !wrk_start_ff || (wrk_idx_ff == wsfe_pkg::last_idx(wrk_kind_ff));
      emit     = wrk_valid_ff && out_load;
      if (wrk_start_ff) begin
         cur_byte = wsfe_pkg::hdr_byte(wrk_kind_ff, wrk_idx_ff, wrk_len_ff, wrk_key_ff);
         cur_eof  = wrk_last && (wrk_len_ff == 32'd0);
      end else begin
         cur_byte = wrk_byte_ff;
         cur_eof  = wrk_eof_ff;
      end
   end

   // Take a new beat when the work register is empty or empties this cycle
   assign req_stall = wrk_valid_ff && !(emit && wrk_last);
   assign accept    = req_valid && !req_stall;
   assign left_dec  = bytes_left_ff - 32'd1;

   // Load the work register and advance the frame state on accept
   always_comb begin
      held_key_in   = held_key_ff;
      bytes_left_in = bytes_left_ff;
      key_pos_in    = key_pos_ff;
      frame_open_in = frame_open_ff;

      wrk_valid_in = wrk_valid_ff;
      wrk_start_in = wrk_start_ff;
      wrk_kind_in  = wrk_kind_ff;
      wrk_len_in   = wrk_len_ff;
      wrk_key_in   = wrk_key_ff;
      wrk_byte_in  = wrk_byte_ff;
      wrk_eof_in   = wrk_eof_ff;
      wrk_err_in   = wrk_err_ff;
      wrk_idx_in   = wrk_idx_ff;

      if (emit) begin
         wrk_idx_in = wrk_idx_ff + 4'd1;
         if (wrk_last) begin
            wrk_valid_in = 1'b0;
         end
      end

      if (accept) begin
         wrk_valid_in = 1'b1;
         wrk_idx_in   = 4'd0;
         wrk_len_in   = req_payload_length;
         wrk_key_in   = req_mask_key;
         wrk_kind_in  = wsfe_pkg::len_kind(req_payload_length);
         if (req_action == wsfe_pkg::ACT_START) begin
            wrk_start_in  = 1'b1;
            wrk_err_in    = frame_open_ff;
            wrk_byte_in   = 8'h00;
            wrk_eof_in    = 1'b0;
            held_key_in   = req_mask_key;
            bytes_left_in = req_payload_length;
            key_pos_in    = 2'd0;
            frame_open_in = (req_payload_length != 32'd0);
         end else if (!frame_open_ff) begin
            // Payload with no open frame: flag it, leave state alone
            wrk_start_in = 1'b0;
            wrk_err_in   = 1'b1;
            wrk_byte_in  = 8'h00;
            wrk_eof_in   = 1'b0;
         end else begin
            wrk_start_in  = 1'b0;
            wrk_err_in    = 1'b0;
            wrk_byte_in   = req_data_byte ^ wsfe_pkg::key_byte(held_key_ff, key_pos_ff);
            wrk_eof_in    = (left_dec == 32'd0);
            key_pos_in    = key_pos_ff + 2'd1;
            bytes_left_in = left_dec;
            frame_open_in = (left_dec != 32'd0);
         end
      end
   end

   // Result register: load when empty or drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eof_in   = rsp_eof_ff;
      rsp_err_in   = rsp_err_ff;
      if (out_load) begin
         rsp_valid_in = wrk_valid_ff;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = wrk_last;
         rsp_eof_in   = cur_eof;
         rsp_err_in   = wrk_err_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_key_ff   <= 32'd0;
         bytes_left_ff <= 32'd0;
         key_pos_ff    <= 2'd0;
         frame_open_ff <= 1'b0;
         wrk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_key_ff   <= held_key_in;
         bytes_left_ff <= bytes_left_in;
         key_pos_ff    <= key_pos_in;
         frame_open_ff <= frame_open_in;
         wrk_valid_ff  <= wrk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wrk_start_ff <= wrk_start_in;
      wrk_kind_ff  <= wrk_kind_in;
      wrk_len_ff   <= wrk_len_in;
      wrk_key_ff   <= wrk_key_in;
      wrk_byte_ff  <= wrk_byte_in;
      wrk_eof_ff   <= wrk_eof_in;
      wrk_err_ff   <= wrk_err_in;
      wrk_idx_ff   <= wrk_idx_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_eof_ff   <= rsp_eof_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_end_of_frame   = rsp_eof_ff;
   assign rsp_sequence_error = rsp_err_ff;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for websocket_binary_frame_encoder_top: a table of frame sequences,
// then random frames, checked beat by beat against a frame-encoding predictor.
// Depends on wsfe_pkg and the encoder top level.
module tb;

   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 410;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 20;
   localparam int NUM_ROWS     = 22;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_frame;
      logic       sequence_error;
   } frame_byte_type;

   typedef struct packed {
      logic           act;
      logic [31:0]    len;
      logic [31:0]    key;
      logic [7:0]     data;
      logic           typed;
      frame_byte_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [31:0] req_payload_length;
   logic [31:0] req_mask_key;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        rsp_end_of_frame;
   logic        rsp_sequence_error;

   // Predictor state of the encoder
   logic [31:0] enc_key;
   logic [31:0] enc_left;
   logic [1:0]  enc_key_idx;
   logic        enc_open;

   frame_byte_type expected_bytes [$];
   int             mismatches;
   int             beats_sent;
   int             idle_cycles;
   int             burst_left [2];

   // Error beats and one payload beat typed from the special cases, the rest left to the predictor
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
      '{wsfe_pkg::ACT_START, 32'd0,       32'hA5A5_5A5A, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h3C, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
      '{wsfe_pkg::ACT_START, 32'd1,       32'hFFFF_FFFF, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
      '{wsfe_pkg::ACT_START, 32'd125,     32'h0123_4567, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'hAB, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h55, 1'b0, '0},
      '{wsfe_pkg::ACT_START, 32'd126,     32'h89AB_CDEF, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_START, 32'd65535,   32'h0000_0000, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_START, 32'd65536,   32'hFFFF_FFFF, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_START, 32'hFFFF_FFFF, 32'h1234_5678, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'hFF, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h80, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h7F, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h01, 1'b0, '0},
      '{wsfe_pkg::ACT_START, 32'd3,       32'hDEAD_BEEF, 8'h00, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h11, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h22, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h33, 1'b0, '0},
      '{wsfe_pkg::ACT_DATA,  32'd0,       32'h0000_0000, 8'h44, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}}
   };

   websocket_binary_frame_encoder_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_payload_length (req_payload_length),
      .req_mask_key       (req_mask_key),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .rsp_sequence_error (rsp_sequence_error)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Key byte for a position; position 0 is the top byte
   function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [31:0] shifted;
      shifted = key >> (5'd24 - 5'd8 * idx);
      return shifted[7:0];
   endfunction

   // Gap length for one side: mostly none or short, a few long, with idle-free stretches
   function automatic int pick_gap(input int side);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (burst_left[side] > 0) begin
         burst_left[side]--;
         gap = 0;
      end else if (r < 2) begin
         burst_left[side] = $urandom_range(20, 40);
         gap = 0;
      end else if (r < 55) begin
         gap = 0;
      end else if (r < 85) begin
         gap = $urandom_range(1, 3);
      end else if (r < 97) begin
         gap = $urandom_range(4, 12);
      end else begin
         gap = $urandom_range(20, 60);
      end
      return gap;
   endfunction

   // Encode one accepted beat and queue the frame bytes it should produce
   task automatic encode_frame_step(input logic act, input logic [31:0] len,
                                    input logic [31:0] key, input logic [7:0] data);
      logic [7:0]     hdr [$];
      frame_byte_type fb;
      logic           cut;
      logic           done;
      if (act == wsfe_pkg::ACT_DATA) begin
         if (!enc_open) begin
            fb = '{8'h00, 1'b1, 1'b0, 1'b1};
         end else begin
            done        = (enc_left == 32'd1);
            fb          = '{data ^ mask_byte(enc_key, enc_key_idx), 1'b1, done, 1'b0};
            enc_key_idx = enc_key_idx + 2'd1;
            enc_left    = enc_left - 32'd1;
            if (done) begin
               enc_open = 1'b0;
            end
         end
         expected_bytes.push_back(fb);
      end else begin
         cut = enc_open;
         hdr.push_back(wsfe_pkg::HDR_FIN_BINARY);
         if (len < wsfe_pkg::LEN_MIN16) begin
            hdr.push_back(wsfe_pkg::HDR_MASK_BIT | len[7:0]);
         end else if (len <= wsfe_pkg::LEN_MAX16) begin
            hdr.push_back(wsfe_pkg::HDR_MASK_BIT | {1'b0, wsfe_pkg::LEN_CODE16});
            hdr.push_back(len[15:8]);
            hdr.push_back(len[7:0]);
         end else begin
            hdr.push_back(wsfe_pkg::HDR_MASK_BIT | {1'b0, wsfe_pkg::LEN_CODE64});
            repeat (4) hdr.push_back(8'h00);
            hdr.push_back(len[31:24]);
            hdr.push_back(len[23:16]);
            hdr.push_back(len[15:8]);
            hdr.push_back(len[7:0]);
         end
         for (int i = 0; i < 4; i++) begin
            hdr.push_back(mask_byte(key, i[1:0]));
         end
         enc_key     = key;
         enc_left    = len;
         enc_key_idx = 2'd0;
         enc_open    = (len != 32'd0);
         for (int i = 0; i < hdr.size(); i++) begin
            done = (i == hdr.size() - 1);
            fb   = '{hdr[i], done, done && (len == 32'd0), cut};
            expected_bytes.push_back(fb);
         end
      end
   endtask

   // Drive one beat after a random gap; return at the edge it is accepted
   task automatic send_beat(input logic act, input logic [31:0] len,
                            input logic [31:0] key, input logic [7:0] data);
      int gap;
      gap = pick_gap(0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= act;
      req_payload_length <= len;
      req_mask_key       <= key;
      req_data_byte      <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_frame_step(act, len, key, data);
      beats_sent++;
   endtask

   // Payload beat with junk in the unused fields
   task automatic send_payload();
      send_beat(wsfe_pkg::ACT_DATA, $urandom, $urandom, 8'($urandom_range(0, 255)));
   endtask

   // Stimulus: table walk, then random frame sequences, then drain
   initial begin
      int          pick;
      int          feed;
      logic [31:0] len;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_action         = wsfe_pkg::ACT_START;
      req_payload_length = '0;
      req_mask_key       = '0;
      req_data_byte      = '0;
      enc_key            = '0;
      enc_left           = '0;
      enc_key_idx        = '0;
      enc_open           = 1'b0;
      mismatches         = 0;
      beats_sent         = 0;
      burst_left         = '{0, 0};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_beat(directed_rows[r].act, directed_rows[r].len,
                   directed_rows[r].key, directed_rows[r].data);
         if (directed_rows[r].typed) begin
            void'(expected_bytes.pop_back());
            expected_bytes.push_back(directed_rows[r].want);
         end
      end

      beats_sent = 0;
      while (beats_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len  = $urandom_range(1, 12);
            feed = len;
         end else if (pick < 62) begin
            len  = 32'd0;
            feed = 0;
         end else if (pick < 70) begin
            len  = $urandom_range(126, 150);
            feed = len;
         end else if (pick < 78) begin
            len  = $urandom_range(126, 65535);
            feed = $urandom_range(0, 6);
         end else if (pick < 86) begin
            len  = $urandom | 32'h0001_0000;
            feed = $urandom_range(0, 6);
         end else if (pick < 93) begin
            len  = $urandom_range(2, 12);
            feed = $urandom_range(0, len - 1);
         end else begin
            len  = 32'd0;
            feed = -1;
         end
         if (feed < 0) begin
            // stray payload beats, outside or inside whatever frame is open
            repeat ($urandom_range(1, 3)) send_payload();
         end else begin
            send_beat(wsfe_pkg::ACT_START, len, $urandom, 8'($urandom_range(0, 255)));
            repeat (feed) send_payload();
         end
      end
      req_valid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Result side backpressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         n = pick_gap(1);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result beat: out_byte %0h", rsp_out_byte);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("last_of_run", 8'(want.last_of_run), 8'(rsp_last_of_run));
            check_field("end_of_frame", 8'(want.end_of_frame), 8'(rsp_end_of_frame));
            check_field("sequence_error", 8'(want.sequence_error), 8'(rsp_sequence_error));
         end
      end
   end

   // Watchdog: stop when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule

// ----- files.f -----
sv/wsfe_pkg.sv
sv/websocket_binary_frame_encoder_top.sv
verif/tb.sv
